// ----- rtl/lqs_pkg.sv -----
// ----------------------------------------------------------------------------
// lqs_pkg
// Shared widths, action and status codes, and sequencer states for the
// linear queue with search.
// ----------------------------------------------------------------------------
package lqs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int ACT_W         = 2;
   localparam int STAT_W        = 2;
   localparam int POS_W         = 7;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_SEARCH = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

// ----- rtl/linear_queue_with_search_top.sv -----
// ----------------------------------------------------------------------------
// linear_queue_with_search_top
// Linear (non-circular) array queue with insert, remove, list and search.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low;
// req_action selects insert, remove, list or search, req_value carries the
// element or the search key. Results come back on the rsp_ ports, each for
// exactly one cycle with rsp_valid high; rsp_last marks the final result of
// a command. The receiver cannot stall, so results are never held.
// Insert, and any command on an empty queue, answers in the cycle after the
// command beat and leaves busy low, so a new command may follow at once.
// Remove, list and search walk the store through one registered read port
// and one compare, one entry per cycle: remove answers with the head, list
// of n entries gives a result each cycle, and search answers at the first
// match or after the last entry (n = stored entries, up to DEPTH).
// busy is high while the walk is running.
// Insert reports full once the write position reaches DEPTH, even if
// removals freed entries at the front; both positions return to zero when
// the last element leaves. Reset clears the positions and the sequencer;
// the store needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module linear_queue_with_search_top #(
   parameter int DEPTH = lqs_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lqs_pkg::ACT_W-1:0]             req_action,
   input  logic signed [lqs_pkg::DATA_W-1:0]     req_value,
   output logic                                  rsp_valid,
   output logic [lqs_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [lqs_pkg::DATA_W-1:0]     rsp_element,
   output logic [lqs_pkg::POS_W-1:0]             rsp_position,
   output logic                                  rsp_last
);

   localparam int AW     = $clog2(DEPTH);
   localparam int PW     = $clog2(DEPTH + 1);
   localparam int DATA_W = lqs_pkg::DATA_W;
   localparam int POS_W  = lqs_pkg::POS_W;
   localparam logic [PW-1:0] PTR_ONE   = PW'(1);
   localparam logic [PW-1:0] PTR_DEPTH = PW'(DEPTH);

   lqs_pkg::state_type  state_ff, state_in;
   lqs_pkg::action_type op_ff, op_in;

   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [PW-1:0]            read_pos_ff, read_pos_in;
   logic [PW-1:0]            write_pos_ff, write_pos_in;
   logic [PW-1:0]            scan_ff, scan_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   lqs_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [POS_W-1:0]         rsp_position_ff, rsp_position_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;

   logic                     accept;
   logic                     empty;
   logic                     full;
   logic [PW-1:0]            scan_next;
   logic                     scan_tail;
   logic                     hit;
   logic                     scan_done;
   logic [PW-1:0]            match_ofs;

   assign accept    = start && (state_ff == lqs_pkg::ST_IDLE);
   assign empty     = (read_pos_ff == write_pos_ff);
   assign full      = (write_pos_ff >= PTR_DEPTH);
   assign scan_next = scan_ff + PTR_ONE;
   assign scan_tail = (scan_next >= write_pos_ff);
   assign hit       = (rd_data_ff == key_ff);
   assign match_ofs = scan_ff - read_pos_ff + PTR_ONE;

   always_comb begin
      unique case (op_ff)
         lqs_pkg::ACT_SEARCH: scan_done = hit || scan_tail;
         lqs_pkg::ACT_LIST:   scan_done = scan_tail;
         default:             scan_done = 1'b1;
      endcase
   end

   // store: one write port for insert, one registered read port for the walk
   assign wr_en = accept && (lqs_pkg::action_type'(req_action) == lqs_pkg::ACT_INSERT)
                  && !full;

   always_comb begin
      if (state_ff == lqs_pkg::ST_IDLE) begin
         rd_en   = !empty;
         rd_addr = read_pos_ff[AW-1:0];
      end else begin
         rd_en   = !scan_tail;
         rd_addr = scan_next[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[write_pos_ff[AW-1:0]] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lqs_pkg::ST_IDLE: begin
            if (accept && !empty &&
                lqs_pkg::action_type'(req_action) != lqs_pkg::ACT_INSERT) begin
               state_in = lqs_pkg::ST_SCAN;
            end
         end
         lqs_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = lqs_pkg::ST_IDLE;
            end
         end
         default: state_in = lqs_pkg::ST_IDLE;
      endcase
   end

   // datapath and result beats
   always_comb begin
      op_in           = op_ff;
      key_in          = key_ff;
      read_pos_in     = read_pos_ff;
      write_pos_in    = write_pos_ff;
      scan_in         = scan_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = lqs_pkg::STAT_OK;
      rsp_element_in  = '0;
      rsp_position_in = '0;
      rsp_last_in     = 1'b1;
      unique case (state_ff)
         lqs_pkg::ST_IDLE: begin
            if (accept) begin
               op_in   = lqs_pkg::action_type'(req_action);
               key_in  = req_value;
               scan_in = read_pos_ff;
               if (lqs_pkg::action_type'(req_action) == lqs_pkg::ACT_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_status_in = lqs_pkg::STAT_FULL;
                  end else begin
                     write_pos_in = write_pos_ff + PTR_ONE;
                  end
               end else if (empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lqs_pkg::STAT_EMPTY;
               end
            end
         end
         lqs_pkg::ST_SCAN: begin
            scan_in = scan_next;
            unique case (op_ff)
               lqs_pkg::ACT_LIST: begin
                  rsp_valid_in   = 1'b1;
                  rsp_element_in = rd_data_ff;
                  rsp_last_in    = scan_tail;
               end
               lqs_pkg::ACT_SEARCH: begin
                  if (hit) begin
                     rsp_valid_in    = 1'b1;
                     rsp_position_in = POS_W'(match_ofs);
                  end else if (scan_tail) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = lqs_pkg::STAT_NOT_FOUND;
                  end
               end
               default: begin
                  // remove: head leaves, positions rewind when it was the last
                  rsp_valid_in   = 1'b1;
                  rsp_element_in = rd_data_ff;
                  if (read_pos_ff + PTR_ONE >= write_pos_ff) begin
                     read_pos_in  = '0;
                     write_pos_in = '0;
                  end else begin
                     read_pos_in = read_pos_ff + PTR_ONE;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lqs_pkg::ST_IDLE;
         read_pos_ff  <= '0;
         write_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_pos_ff  <= read_pos_in;
         write_pos_ff <= write_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      key_ff          <= key_in;
      scan_ff         <= scan_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_position_ff <= rsp_position_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign busy         = (state_ff != lqs_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

   // positions stay ordered and inside the store
   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      (read_pos_ff <= write_pos_ff) && (write_pos_ff <= PTR_DEPTH))
      else $error("queue positions out of order");

   // an insert answers with a single final beat in the next cycle
   a_insert_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == lqs_pkg::ACT_INSERT) |=> (rsp_valid && rsp_last))
      else $error("insert gave no final beat");

   // a list beat that is not the last is followed by another beat
   a_list_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("list stream broke off");

   // failure beats carry neither element nor position
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lqs_pkg::STAT_OK) |->
      (rsp_element == '0 && rsp_position == '0 && rsp_last))
      else $error("failure beat carries data");

endmodule
